// File: hw/rtl/text_console_character_writer_assert.svh
// ----------------------------------------------------------------------------
// Text console character writer: assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHARACTER_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHARACTER_WRITER_ASSERT_SVH

// Same-cycle implication.
`define TCCW_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tccw assertion failed");

// Next-cycle implication.
`define TCCW_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tccw assertion failed");

`endif

// File: hw/rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// Text console character writer package
// Screen geometry, codes, payload types and controller/datapath interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELLS      = COLUMNS * ROWS;
	localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;

	localparam int ADDR_W    = $clog2(CELLS);
	localparam int COL_W     = $clog2(COLUMNS + 8);
	localparam int ROW_W     = $clog2(ROWS + 1);
	localparam int CMD_W     = 2;
	localparam int CHAR_W    = 8;
	localparam int CADDR_W   = 11;
	localparam int CURSOR_W  = 11;
	localparam int CELL_W    = 16;
	localparam int COLOR_W   = 4;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 1'b1;

	localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;
	localparam logic [COLOR_W-1:0] FG_RESET = 4'd2;

	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_COPY,
		ST_FILL,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MEM_NONE,
		MEM_ZERO,
		MEM_BLANK,
		MEM_COPY
	} mem_op_t;

	typedef struct packed {
		logic    accept;
		logic    cnt_clr;
		logic    cnt_inc;
		mem_op_t mem_op;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic scroll;
		logic cnt_end;
		logic copy_end;
		logic out_free;
	} dp_sts_t;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [CHAR_W-1:0]  ch;
		logic [CADDR_W-1:0] cell_address;
	} req_t;

	typedef struct packed {
		logic [CURSOR_W-1:0] cursor_pos;
		logic [CELL_W-1:0]   cell_data;
	} rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/tccw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/tccw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console controller
// Sequences command execution, scroll copy, blank fill and the reset sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  logic [tccw_pkg::CMD_W-1:0]   cmd,
	input  tccw_pkg::dp_sts_t            sts,
	output tccw_pkg::dp_cmd_t            dpc,
	output logic                         req_ready
);

	import tccw_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		dpc       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_INIT: begin
				dpc.mem_op = MEM_ZERO;
				if (sts.cnt_end) begin
					state_d = ST_IDLE;
				end else begin
					dpc.cnt_inc = 1'b1;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					dpc.accept = 1'b1;
					if (cmd == CMD_PUT && sts.scroll) begin
						dpc.cnt_clr = 1'b1;
						state_d     = ST_COPY;
					end else if (cmd == CMD_CLEAR) begin
						dpc.cnt_clr = 1'b1;
						state_d     = ST_FILL;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_COPY: begin
				dpc.mem_op = MEM_COPY;
				if (sts.copy_end) begin
					state_d = ST_FILL;
				end else begin
					dpc.cnt_inc = 1'b1;
				end
			end
			ST_FILL: begin
				dpc.mem_op = MEM_BLANK;
				if (sts.cnt_end) begin
					state_d = ST_DONE;
				end else begin
					dpc.cnt_inc = 1'b1;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					dpc.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hw/rtl/tccw_dpath.sv
// ----------------------------------------------------------------------------
// Text console datapath
// Cursor, colors, sweep counter, cell store and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tccw_pkg::req_t                 req,
	input  tccw_pkg::dp_cmd_t              dpc,
	output tccw_pkg::dp_sts_t              sts,
	input  logic                           cfg_we,
	input  logic [tccw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tccw_pkg::COLOR_W-1:0]   cfg_data,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output tccw_pkg::rsp_t                 rsp
);

	import tccw_pkg::*;

	logic [COLOR_W-1:0] bg_q;
	logic [COLOR_W-1:0] fg_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [ADDR_W-1:0]  cnt_q;
	logic               rd_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [COL_W-1:0]  col_d;
	logic [ROW_W-1:0]  row_d;
	logic              scroll_d;
	logic              put_wr;
	logic              rd_ok;
	logic [ADDR_W-1:0] cur_lin;
	logic [CELL_W-1:0] blank;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	assign blank   = {bg_q, fg_q, CH_BLANK};
	assign cur_lin = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
	assign rd_ok   = 32'(req.cell_address) < 32'(CELLS);

	always_comb begin
		col_d  = col_q;
		row_d  = row_q;
		put_wr = 1'b0;
		case (req.ch)
			CH_BS: begin
				if (col_q != '0) begin
					col_d = col_q - COL_W'(1);
				end
			end
			CH_TAB: begin
				col_d = (col_q + COL_W'(8)) & ~COL_W'(7);
			end
			CH_CR: begin
				col_d = '0;
			end
			CH_LF: begin
				col_d = '0;
				row_d = row_q + ROW_W'(1);
			end
			default: begin
				if (!req.ch[7] && req.ch[6:5] != 2'b00) begin
					put_wr = 1'b1;
					col_d  = col_q + COL_W'(1);
				end
			end
		endcase
		if (col_d >= COL_W'(COLUMNS)) begin
			col_d = '0;
			row_d = row_d + ROW_W'(1);
		end
		scroll_d = row_d >= ROW_W'(ROWS);
		if (scroll_d) begin
			row_d = ROW_W'(ROWS - 1);
		end
	end

	assign sts.scroll   = scroll_d;
	assign sts.cnt_end  = cnt_q == ADDR_W'(CELLS - 1);
	assign sts.copy_end = cnt_q == ADDR_W'(COPY_CELLS);
	assign sts.out_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q <= BG_RESET;
			fg_q <= FG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BACKGROUND: bg_q <= cfg_data;
				CFG_FOREGROUND: fg_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (dpc.accept) begin
			if (req.cmd == CMD_PUT) begin
				col_q <= col_d;
				row_q <= row_d;
			end else if (req.cmd == CMD_CLEAR) begin
				col_q <= '0;
				row_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (dpc.cnt_clr) begin
			cnt_q <= '0;
		end else if (dpc.cnt_inc) begin
			cnt_q <= cnt_q + ADDR_W'(1);
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = blank;
		ram_re    = 1'b0;
		ram_raddr = cnt_q + ADDR_W'(COLUMNS);
		case (dpc.mem_op)
			MEM_ZERO: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
			end
			MEM_BLANK: begin
				ram_we = 1'b1;
			end
			MEM_COPY: begin
				ram_we    = cnt_q != '0;
				ram_waddr = cnt_q - ADDR_W'(1);
				ram_wdata = ram_rdata;
				ram_re    = !sts.copy_end;
			end
			default: begin
				if (dpc.accept) begin
					ram_we    = req.cmd == CMD_PUT && put_wr;
					ram_waddr = cur_lin;
					ram_wdata = {bg_q, fg_q, req.ch};
					ram_re    = req.cmd == CMD_READ && rd_ok;
					ram_raddr = ADDR_W'(req.cell_address);
				end
			end
		endcase
	end

	tccw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (dpc.accept) begin
			rd_q <= req.cmd == CMD_READ && rd_ok;
		end
		if (dpc.out_load) begin
			rsp_q.cursor_pos <= CURSOR_W'(cur_lin);
			rsp_q.cell_data  <= rd_q ? ram_rdata : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (dpc.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// File: hw/rtl/text_console_character_writer.sv
// ----------------------------------------------------------------------------
// Text console character writer
// Text-mode terminal engine with a cell store, cursor, scroll and clear.
// ----------------------------------------------------------------------------
//  Channel  Signals                               Role
//  req      req_valid, req_ready, req             command in (cmd, ch, cell_address)
//  rsp      rsp_valid, rsp_ready, rsp             result out (cursor_pos, cell_data)
//  cfg      cfg_valid, cfg_ready, cfg_index/data  color register writes
//
// Put, read and the unused command are accepted, then their result is loaded
// once the result register is free. A put that scrolls adds a row copy pass
// and a fill of the last row, set by the one read and one write port of the
// cell store. Clear adds a blank fill of the whole store. After reset a sweep
// zeroes the store while req_ready is low. The result register lets the next
// command be accepted while a result waits; cfg is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_character_writer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  tccw_pkg::req_t                 req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output tccw_pkg::rsp_t                 rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tccw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tccw_pkg::COLOR_W-1:0]   cfg_data
);

	import tccw_pkg::*;

	dp_cmd_t dpc;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	tccw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.cmd      (req.cmd),
		.sts      (sts),
		.dpc      (dpc),
		.req_ready(req_ready)
	);

	tccw_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.dpc      (dpc),
		.sts      (sts),
		.cfg_we   (cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

// File: hw/rtl/tccw_chk.sv
// ----------------------------------------------------------------------------
// Text console port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_character_writer_assert.svh"

module tccw_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input tccw_pkg::rsp_t rsp
);

	import tccw_pkg::*;

	// A stalled result transaction keeps its payload.
	`TCCW_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

	// A result is withdrawn only after it was taken.
	`TCCW_ASSERT_IMP(a_rsp_drop, $fell(rsp_valid), $past(rsp_ready))

	// Each command is executed alone, so ready drops right after acceptance.
	`TCCW_ASSERT_NXT(a_one_cmd, req_valid && req_ready, !req_ready)

	// The reported cursor always lies on the screen.
	`TCCW_ASSERT_IMP(a_cursor_range, rsp_valid, 32'(rsp.cursor_pos) < 32'(CELLS))

endmodule

bind text_console_character_writer tccw_chk u_chk (.*);

`default_nettype wire

// File: bench/text_console_character_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console character writer testbench
// Drives put, clear, read and unused commands through the request channel,
// keeps its own copy of the screen, cursor and colors, and checks each
// result transaction field by field against the predicted one.
// ----------------------------------------------------------------------------
module text_console_character_writer_tb;
	import tccw_pkg::*;

	localparam int                 CYCLE_LIMIT   = 10_000_000;
	localparam int                 SETTLE_CYCLES = 16;
	localparam int                 MAX_REPORTS   = 10;
	localparam int                 PHASES        = 5;
	localparam int                 PHASE_ITEMS   = 190;
	localparam logic [CMD_W-1:0]   CMD_UNUSED    = 2'd3;
	localparam logic [CHAR_W-1:0]  CH_LAST_PRINT = 8'h7F;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_ready;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_ready;
	rsp_t                 rsp;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COLOR_W-1:0]   cfg_data;

	logic [CELL_W-1:0]  screen_model [CELLS];
	int                 cursor_col = 0;
	int                 cursor_line = 0;
	logic [COLOR_W-1:0] cur_bg = BG_RESET;
	logic [COLOR_W-1:0] cur_fg = FG_RESET;
	rsp_t               pending_results [$];
	int                 mismatch_count = 0;
	int                 cycle_count = 0;
	int                 hold_off = 0;
	bit                 no_idle = 1'b0;

	text_console_character_writer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** text_console_character_writer: FAILED **");
		$finish;
	end

	function automatic rsp_t console_step(input req_t c);
		rsp_t              r;
		logic [CELL_W-1:0] blank;
		blank = {cur_bg, cur_fg, CH_BLANK};
		r = '0;
		case (c.cmd)
			CMD_PUT: begin
				if (c.ch == CH_BS) begin
					if (cursor_col != 0)
						cursor_col--;
				end else if (c.ch == CH_TAB) begin
					cursor_col = (cursor_col + 8) & ~7;
				end else if (c.ch == CH_CR) begin
					cursor_col = 0;
				end else if (c.ch == CH_LF) begin
					cursor_col = 0;
					cursor_line++;
				end else if (c.ch >= CH_BLANK && c.ch <= CH_LAST_PRINT) begin
					screen_model[cursor_line * COLUMNS + cursor_col] = {cur_bg, cur_fg, c.ch};
					cursor_col++;
				end
				if (cursor_col >= COLUMNS) begin
					cursor_col = 0;
					cursor_line++;
				end
				if (cursor_line >= ROWS) begin
					for (int i = 0; i < COPY_CELLS; i++)
						screen_model[i] = screen_model[i + COLUMNS];
					for (int i = COPY_CELLS; i < CELLS; i++)
						screen_model[i] = blank;
					cursor_line = ROWS - 1;
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen_model[i] = blank;
				cursor_col = 0;
				cursor_line = 0;
			end
			CMD_READ: begin
				if (c.cell_address < CELLS)
					r.cell_data = screen_model[c.cell_address];
			end
			default: ;
		endcase
		r.cursor_pos = CURSOR_W'(cursor_line * COLUMNS + cursor_col);
		return r;
	endfunction

	// Accepts results, stalls at random, and honors long hold-off requests.
	initial begin : result_monitor
		rsp_t want;
		int   stall;
		bit   taken;
		stall = 0;
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			taken = rsp_valid && rsp_ready;
			if (taken) begin
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("Unexpected result: cursor_pos %0d cell_data %h",
							rsp.cursor_pos, rsp.cell_data);
				end else begin
					want = pending_results.pop_front();
					if (rsp.cursor_pos !== want.cursor_pos || rsp.cell_data !== want.cell_data) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("Mismatch: cursor_pos exp %0d got %0d, cell_data exp %h got %h",
								want.cursor_pos, rsp.cursor_pos, want.cell_data, rsp.cell_data);
					end
				end
			end
			if (hold_off > 0) begin
				stall = hold_off;
				hold_off = 0;
			end else if (taken) begin
				stall = no_idle ? 0 : $urandom_range(0, 3);
			end
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				stall--;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	task automatic issue_command(input req_t item);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
		pending_results.push_back(console_step(item));
	endtask

	task automatic send(input logic [CMD_W-1:0] op, input logic [CHAR_W-1:0] c,
			input logic [CADDR_W-1:0] addr);
		req_t item;
		item.cmd          = op;
		item.ch           = c;
		item.cell_address = addr;
		issue_command(item);
	endtask

	task automatic put_char(input logic [CHAR_W-1:0] c);
		send(CMD_PUT, c, CADDR_W'($urandom));
	endtask

	task automatic read_cell(input logic [CADDR_W-1:0] addr);
		send(CMD_READ, CHAR_W'($urandom), addr);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_colors(input logic [COLOR_W-1:0] bg, input logic [COLOR_W-1:0] fg);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_BACKGROUND;
		cfg_data  <= bg;
		do @(posedge clk); while (!cfg_ready);
		cur_bg = bg;
		cfg_index <= CFG_FOREGROUND;
		cfg_data  <= fg;
		do @(posedge clk); while (!cfg_ready);
		cur_fg = fg;
		cfg_valid <= 1'b0;
	endtask

	function automatic req_t random_command();
		req_t c;
		int   sel;
		int   pos;
		c.cmd          = CMD_PUT;
		c.ch           = CHAR_W'($urandom_range(CH_BLANK, CH_LAST_PRINT));
		c.cell_address = CADDR_W'($urandom_range(0, 2047));
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			case ($urandom_range(0, 3))
				0: c.ch = CH_BS;
				1: c.ch = CH_TAB;
				2: c.ch = CH_CR;
				default: c.ch = CH_LF;
			endcase
		end else if (sel < 13) begin
			c.ch = CHAR_W'($urandom_range(0, 255));
		end else if (sel < 27) begin
			c.cmd = CMD_READ;
			pos = cursor_line * COLUMNS + cursor_col - $urandom_range(1, 120);
			c.cell_address = CADDR_W'((pos < 0) ? 0 : pos);
		end else if (sel < 33) begin
			c.cmd = CMD_READ;
		end else if (sel < 34) begin
			c.cmd = CMD_CLEAR;
		end else if (sel < 36) begin
			c.cmd = CMD_UNUSED;
		end
		return c;
	endfunction

	task automatic test_reset_state();
		read_cell(CADDR_W'(0));
		read_cell(CADDR_W'(CELLS - 1));
		read_cell(CADDR_W'(2047));
		send(CMD_UNUSED, CHAR_W'($urandom), CADDR_W'($urandom));
	endtask

	task automatic test_put_characters();
		put_char(8'h41);
		put_char(CH_BLANK);
		put_char(CH_LAST_PRINT);
		put_char(8'h1F);
		put_char(8'h00);
		put_char(8'h80);
		put_char(8'hFF);
		read_cell(CADDR_W'(0));
		read_cell(CADDR_W'(1));
		read_cell(CADDR_W'(2));
		set_colors(4'hF, 4'hF);
		put_char(8'h5A);
		read_cell(CADDR_W'(3));
	endtask

	task automatic test_control_codes();
		put_char(CH_BS);
		put_char(CH_TAB);
		put_char(CH_CR);
		put_char(CH_BS);
		put_char(CH_TAB);
		put_char(CH_LF);
		put_char(8'h7E);
		read_cell(CADDR_W'(COLUMNS));
	endtask

	task automatic test_scroll_and_wrap();
		set_colors(4'h0, 4'h0);
		send(CMD_CLEAR, CHAR_W'($urandom), CADDR_W'($urandom));
		put_char(CH_LF);
		put_char(8'h53);
		repeat (ROWS - 1) put_char(CH_LF);
		read_cell(CADDR_W'(0));
		read_cell(CADDR_W'(CELLS - 1));
		repeat (COLUMNS / 8) put_char(CH_TAB);
		read_cell(CADDR_W'(0));
	endtask

	task automatic test_backpressure();
		drain();
		no_idle  = 1'b1;
		hold_off = 400;
		repeat (24) put_char(CHAR_W'($urandom_range(CH_BLANK, CH_LAST_PRINT)));
		no_idle = 1'b0;
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == 0)
				set_colors(4'hF, 4'h0);
			else
				set_colors(COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)));
			no_idle = (phase == 2);
			repeat (PHASE_ITEMS) issue_command(random_command());
			no_idle = 1'b0;
		end
	endtask

	initial begin
		for (int i = 0; i < CELLS; i++)
			screen_model[i] = '0;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_BACKGROUND;
		cfg_data  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_put_characters();
		test_control_codes();
		test_scroll_and_wrap();
		test_backpressure();
		test_random_traffic();

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("** text_console_character_writer: PASSED **");
		else
			$display("** text_console_character_writer: FAILED **");
		$finish;
	end

endmodule
